@@ hw/rtl/lnco_pkg.sv @@
`timescale 1ns / 1ps

package lnco_pkg;

   // Default sizing handed to the top level.
   localparam int DEF_CAPACITY = 16;
   localparam int DEF_ID_BITS  = 16;

   // Fixed field widths of the stream and configuration ports.
   localparam int NODE_ID_W    = 16;
   localparam int KIND_W       = 2;
   localparam int RSP_DATA_W   = 24;
   localparam int CSR_W        = 5;

   localparam logic [CSR_W-1:0] MAX_ENTRIES_RESET = 5'd16;

   // Result kinds carried on rsp_tuser.
   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EVICT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   // Input modes carried on req_tuser.
   localparam logic MODE_TOUCH = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

endpackage

@@ hw/rtl/lnco_order_ram.sv @@
`timescale 1ns / 1ps

module lnco_order_ram #(
   parameter int DEPTH = lnco_pkg::DEF_CAPACITY + 1,
   parameter int WIDTH = lnco_pkg::DEF_ID_BITS,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/lru_node_cache_order_core.sv @@
`timescale 1ns / 1ps

// A clear, or a touch with the limit at zero and the list empty, moves straight to its result
// state after acceptance. Any other touch walks the recency memory one slot per cycle, so its
// acknowledgement is loaded once the walk reaches the slot of the id, or the entry count if absent.
// Each eviction then takes a read state and a result-load state.
// Throughput: one transaction at a time; the single-port-read walk over the memory sets it.
// Reset: the entry count clears and max_entries returns to 16; the memory is not cleared.
module lru_node_cache_order_core #(
   parameter int CAPACITY = lnco_pkg::DEF_CAPACITY,
   parameter int ID_BITS  = lnco_pkg::DEF_ID_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration: max_entries.
   input  logic                              csr_we,
   input  logic [lnco_pkg::CSR_W-1:0]        csr_wdata,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lnco_pkg::NODE_ID_W-1:0]    req_tdata,   // [15:0] node_id
   input  logic                              req_tuser,   // [0] mode
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lnco_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [15:0] result_id, [16] newly_held
   output logic [lnco_pkg::KIND_W-1:0]       rsp_tuser,   // [1:0] kind
   output logic                              rsp_tlast
);

   localparam int CNT_W = $clog2(CAPACITY + 2);
   localparam int AW    = $clog2(CAPACITY + 1);
   localparam int ST_W  = 3;

   localparam logic [ST_W-1:0] ST_IDLE      = 3'd0;
   localparam logic [ST_W-1:0] ST_SCAN      = 3'd1;
   localparam logic [ST_W-1:0] ST_ACK       = 3'd2;
   localparam logic [ST_W-1:0] ST_CLEAR     = 3'd3;
   localparam logic [ST_W-1:0] ST_EVICT_RD  = 3'd4;
   localparam logic [ST_W-1:0] ST_EVICT_OUT = 3'd5;

   logic [ST_W-1:0]     state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [ID_BITS-1:0]  carry_ff, carry_in;
   logic                held_ff, held_in;
   logic [lnco_pkg::CSR_W-1:0] max_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lnco_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [lnco_pkg::NODE_ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic                          rsp_held_ff, rsp_held_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [ID_BITS-1:0] ram_wdata, ram_rdata;

   logic [CNT_W-1:0] limit;
   logic             req_fire;
   logic             out_free;
   logic             over_limit;

   lnco_order_ram #(
      .DEPTH (CAPACITY + 1),
      .WIDTH (ID_BITS)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // A limit above the memory capacity acts as the capacity.
   always_comb begin
      if (32'(max_ff) > 32'(CAPACITY)) begin
         limit = CNT_W'(CAPACITY);
      end else begin
         limit = CNT_W'(max_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign over_limit = count_ff > limit;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      id_in        = id_ff;
      carry_in     = carry_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_held_in  = rsp_held_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[AW-1:0];
      ram_wdata    = carry_ff;
      ram_re       = 1'b0;
      ram_raddr    = idx_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               id_in    = ID_BITS'(req_tdata);
               carry_in = ID_BITS'(req_tdata);
               held_in  = 1'b0;
               idx_in   = '0;
               if (req_tuser == lnco_pkg::MODE_CLEAR) begin
                  count_in = '0;
                  state_in = ST_CLEAR;
               end else if (limit == '0 && count_ff == '0) begin
                  state_in = ST_ACK;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  state_in  = ST_SCAN;
               end
            end
         end

         // Each cycle writes the carried id into the current slot and picks up the
         // old content as the next carry, until the id is found or the end is passed.
         ST_SCAN: begin
            ram_we = 1'b1;
            if (idx_ff == count_ff) begin
               held_in  = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = ST_ACK;
            end else if (ram_rdata == id_ff) begin
               state_in = ST_ACK;
            end else begin
               carry_in  = ram_rdata;
               idx_in    = idx_ff + CNT_W'(1);
               ram_re    = 1'b1;
               ram_raddr = idx_in[AW-1:0];
            end
         end

         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = lnco_pkg::KIND_ACK;
               rsp_id_in    = lnco_pkg::NODE_ID_W'(id_ff);
               rsp_held_in  = held_ff;
               rsp_last_in  = !over_limit;
               state_in     = over_limit ? ST_EVICT_RD : ST_IDLE;
            end
         end

         ST_CLEAR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = lnco_pkg::KIND_CLEAR;
               rsp_id_in    = '0;
               rsp_held_in  = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_EVICT_RD: begin
            count_in  = count_ff - CNT_W'(1);
            ram_re    = 1'b1;
            ram_raddr = count_in[AW-1:0];
            state_in  = ST_EVICT_OUT;
         end

         ST_EVICT_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = lnco_pkg::KIND_EVICT;
               rsp_id_in    = lnco_pkg::NODE_ID_W'(ram_rdata);
               rsp_held_in  = 1'b0;
               rsp_last_in  = !over_limit;
               state_in     = over_limit ? ST_EVICT_RD : ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         max_ff       <= lnco_pkg::MAX_ENTRIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      id_ff       <= id_in;
      carry_ff    <= carry_in;
      held_ff     <= held_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_held_ff <= rsp_held_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(lnco_pkg::RSP_DATA_W - lnco_pkg::NODE_ID_W - 1){1'b0}},
                        rsp_held_ff, rsp_id_ff};

   // The walk never passes the slot just beyond the valid entries.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> idx_ff <= count_ff)
      else $error("scan index beyond entry count");

   // Between transactions the list never holds more than the capacity.
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity while idle");

   // A clear empties the list at once.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == lnco_pkg::MODE_CLEAR |=> count_ff == '0)
      else $error("clear did not empty the list");

   // A result marked last returns the block to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACK || state_ff == ST_EVICT_OUT) && out_free && !over_limit
      |=> state_ff == ST_IDLE && rsp_last_ff)
      else $error("final result did not end the transaction");

endmodule

@@ tb/sv/tb_lru_node_cache_order_core.sv @@
`timescale 1ns / 1ps

module tb_lru_node_cache_order_core;
   import lnco_pkg::*;

   localparam int CAPACITY    = DEF_CAPACITY;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 40;

   typedef struct packed {
      logic                 mode;
      logic [NODE_ID_W-1:0] node_id;
   } node_request_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [NODE_ID_W-1:0] result_id;
      logic                 newly_held;
      logic                 last;
   } lru_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [NODE_ID_W-1:0]  req_tdata  = '0;
   logic                  req_tuser  = MODE_TOUCH;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   lru_node_cache_order_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   node_request_type node_requests[$];
   lru_result_type   owed_results[$];
   int            queued      = 0;
   int            accepted    = 0;
   int            fail_count  = 0;
   int            cycle_count = 0;
   bit            bursts_on   = 1'b1;
   bit            hold_request = 1'b0;
   bit            hold_done   = 1'b0;
   int            hold_cnt    = 0;
   int            req_gap     = 0;
   int            rsp_gap     = 0;

   // Local copy of the recency list; slot 0 is the most recently used id.
   logic [NODE_ID_W-1:0] mirror_order [0:CAPACITY];
   int                   mirror_count = 0;
   logic [CSR_W-1:0]     mirror_limit = MAX_ENTRIES_RESET;

   function automatic void owe(logic [KIND_W-1:0] kind, logic [NODE_ID_W-1:0] rid,
                               logic held);
      owed_results.push_back('{kind, rid, held, 1'b0});
   endfunction

   function automatic void advance_recency_list(node_request_type rq);
      int   limit;
      int   pos;
      int   i;
      logic held;
      held = 1'b0;
      if (rq.mode == MODE_CLEAR) begin
         mirror_count = 0;
         owed_results.push_back('{KIND_CLEAR, '0, 1'b0, 1'b1});
         return;
      end
      limit = (mirror_limit > CAPACITY) ? CAPACITY : int'(mirror_limit);
      if (mirror_count > CAPACITY) mirror_count = CAPACITY;
      if ((limit > 0 || mirror_count > 0) &&
          (mirror_count == 0 || mirror_order[0] != rq.node_id)) begin
         pos = mirror_count;
         for (i = 0; i < mirror_count; i++)
            if (pos == mirror_count && mirror_order[i] == rq.node_id) pos = i;
         if (pos == mirror_count) begin
            held = 1'b1;
            mirror_count++;
         end
         for (i = pos; i > 0; i--) mirror_order[i] = mirror_order[i-1];
         mirror_order[0] = rq.node_id;
      end
      owe(KIND_ACK, rq.node_id, held);
      while (mirror_count > limit) begin
         mirror_count--;
         owe(KIND_EVICT, mirror_order[mirror_count], 1'b0);
      end
      owed_results[owed_results.size()-1].last = 1'b1;
   endfunction

   function automatic void check_field(string name, logic [NODE_ID_W-1:0] want,
                                       logic [NODE_ID_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Request driver: a new transaction is offered only once the previous one is taken.
   always @(posedge clock) begin : request_driver
      node_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap != 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (bursts_on && $urandom_range(0, 9) == 0) begin
            req_gap    <= $urandom_range(0, 5);
            req_tvalid <= 1'b0;
         end else if (node_requests.size() != 0) begin
            nxt = node_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.node_id;
            req_tuser  <= nxt.mode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response sink, including one long hold-off that backs the block up.
   always @(posedge clock) begin : response_sink
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt   <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_cnt   <= HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap    <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
         rsp_gap    <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      lru_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual kind %0d id %h held %b last %b",
                        $time, rsp_tuser, rsp_tdata[15:0], rsp_tdata[16], rsp_tlast);
               fail_count++;
            end else begin
               want = owed_results.pop_front();
               check_field("kind", NODE_ID_W'(want.kind), NODE_ID_W'(rsp_tuser));
               check_field("result_id", want.result_id, rsp_tdata[15:0]);
               check_field("newly_held", NODE_ID_W'(want.newly_held),
                           NODE_ID_W'(rsp_tdata[16]));
               check_field("last", NODE_ID_W'(want.last), NODE_ID_W'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            advance_recency_list('{req_tuser, req_tdata});
            accepted++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic queue_request(logic mode, logic [NODE_ID_W-1:0] nid);
      node_requests.push_back('{mode, nid});
      queued++;
   endtask

   task automatic wait_for_idle();
      while (accepted != queued || owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // The register is only written once the block has gone quiet.
   task automatic set_max_entries(logic [CSR_W-1:0] value);
      wait_for_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      mirror_limit = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly ids from a small pool so that hits, moves and evictions are common.
   task automatic queue_random_requests(int count, int pool);
      logic [NODE_ID_W-1:0] base;
      logic [NODE_ID_W-1:0] nid;
      int                   k;
      base = NODE_ID_W'($urandom());
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 4) == 0) nid = NODE_ID_W'($urandom());
         else nid = base + NODE_ID_W'($urandom_range(0, pool - 1));
         queue_request(($urandom_range(0, 19) == 0) ? MODE_CLEAR : MODE_TOUCH, nid);
      end
   endtask

   initial begin : stimulus
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset limit of 16: insert, repeat at the MRU end, move from the LRU end, clear.
      queue_request(MODE_TOUCH, 16'h0000);
      queue_request(MODE_TOUCH, 16'hFFFF);
      queue_request(MODE_TOUCH, 16'hFFFF);
      queue_request(MODE_TOUCH, 16'h0000);
      queue_request(MODE_CLEAR, 16'h5A5A);
      for (k = 0; k < CAPACITY; k++) queue_request(MODE_TOUCH, 16'h1000 + NODE_ID_W'(k));

      // A new id into a full list with the limit at zero evicts everything.
      set_max_entries(5'd0);
      queue_request(MODE_TOUCH, 16'hABCD);
      queue_request(MODE_TOUCH, 16'h1234);

      // A limit above capacity acts as capacity.
      set_max_entries(5'd31);
      queue_random_requests(40, 24);

      // Lowering the limit makes the next touch evict a long run.
      set_max_entries(5'd2);
      queue_random_requests(25, 6);

      set_max_entries(5'd1);
      queue_random_requests(15, 3);

      set_max_entries(CSR_W'($urandom_range(3, 15)));
      hold_request = 1'b1;
      queue_random_requests(45, 20);

      set_max_entries(5'd16);
      queue_random_requests(25, 20);

      set_max_entries(CSR_W'($urandom_range(0, 31)));
      bursts_on = 1'b0;
      queue_random_requests(30, 12);

      wait_for_idle();
      if (fail_count == 0 && owed_results.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
